// ===== src/rfh_pkg.sv =====
// Shared types and constants of the RNG FIFO health reader.
package rfh_pkg;

    localparam int MAX_BYTES = 4096;
    localparam int LEN_W     = 13;
    // wide enough to hold MAX_BYTES at the top of its range
    localparam int LEN_CMP_W = 17;
    localparam int WAIT_BITS = 16;
    localparam int REPEAT_FAIL = 4;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_POLL  = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_ACTIVE  = 2'd1;
    localparam logic [1:0] PH_CLOSING = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_NOT_READY = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_HEALTH    = 3'd4;
    localparam logic [2:0] ST_TIMEOUT   = 3'd5;
    localparam logic [2:0] ST_WAITING   = 3'd6;

    localparam logic [1:0] REG_FAILURE_MASK = 2'd0;
    localparam logic [1:0] REG_ENABLE_MASK  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_MS   = 2'd2;

    localparam logic       KIND_DATA   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [1:0]       mode;
        logic [LEN_W-1:0] request_length;
        logic [31:0]      now_ms;
        logic             cancel_flag;
        logic [31:0]      control_word;
        logic [31:0]      status_word;
        logic [31:0]      bit_count;
        logic [31:0]      fifo_count;
        logic [31:0]      fifo_word;
    } item_t;

    typedef struct packed {
        logic [31:0] failure_mask;
        logic [31:0] enable_mask;
        logic [15:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
        logic [2:0] status_code;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [2:0]       count;
        result_t [3:0]    res;
    } res_bundle_t;

endpackage

// ===== src/rfh_core.sv =====
// Request state and combinational evaluation of one item into its results.
module rfh_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  rfh_pkg::item_t       item,
    input  rfh_pkg::cfg_t        cfg,
    output rfh_pkg::res_bundle_t bundle
);

    logic                    failed_latch_reg, failed_latch_next;
    logic [2:0]              repeat_count_reg, repeat_count_next;
    logic [31:0]             previous_word_reg, previous_word_next;
    logic [rfh_pkg::LEN_W-1:0] bytes_done_reg, bytes_done_next;
    logic [rfh_pkg::LEN_W-1:0] bytes_wanted_reg, bytes_wanted_next;
    logic [31:0]             start_time_reg, start_time_next;
    logic [1:0]              phase_reg, phase_next;

    logic [rfh_pkg::LEN_CMP_W-1:0] len_wide;
    logic                    len_bad;
    logic [31:0]             elapsed;
    logic                    timed_out;
    logic                    absent;
    logic                    health_bits;
    logic                    enabled;
    logic                    waiting;
    logic [2:0]              rep_calc;
    logic [rfh_pkg::LEN_W-1:0] left;
    logic [2:0]              n;
    rfh_pkg::result_t        status_res;

    assign len_wide    = rfh_pkg::LEN_CMP_W'(item.request_length);
    assign len_bad     = (item.request_length == '0)
                      || (len_wide > rfh_pkg::LEN_CMP_W'(rfh_pkg::MAX_BYTES));
    assign elapsed     = item.now_ms - start_time_reg;
    assign timed_out   = elapsed >= {16'd0, cfg.timeout_ms};
    assign absent      = (item.control_word == '1) || (item.status_word == '1);
    assign health_bits = (item.status_word & cfg.failure_mask) != '0;
    assign enabled     = (item.control_word & cfg.enable_mask) != '0;
    assign waiting     = (item.bit_count <= 32'(rfh_pkg::WAIT_BITS))
                      || (item.fifo_count[7:0] == 8'd0);

    // repetition count: restart on a new word, saturate at seven
    always_comb
    begin
        if (repeat_count_reg != 3'd0 && previous_word_reg == item.fifo_word)
        begin
            rep_calc = (repeat_count_reg < 3'd7) ? repeat_count_reg + 3'd1 : 3'd7;
        end
        else
        begin
            rep_calc = 3'd1;
        end
    end

    assign left = (bytes_wanted_reg > bytes_done_reg) ? bytes_wanted_reg - bytes_done_reg
                                                      : '0;
    assign n    = (left < rfh_pkg::LEN_W'(4)) ? left[2:0] : 3'd4;

    always_comb
    begin
        failed_latch_next  = failed_latch_reg;
        repeat_count_next  = repeat_count_reg;
        previous_word_next = previous_word_reg;
        bytes_done_next    = bytes_done_reg;
        bytes_wanted_next  = bytes_wanted_reg;
        start_time_next    = start_time_reg;
        phase_next         = phase_reg;

        status_res             = '0;
        status_res.kind        = rfh_pkg::KIND_STATUS;
        status_res.last        = 1'b1;
        bundle                 = '0;

        case (item.mode)
            rfh_pkg::MODE_START:
            begin
                if (len_bad)
                begin
                    phase_next             = rfh_pkg::PH_IDLE;
                    status_res.status_code = rfh_pkg::ST_INVALID;
                    bundle.count           = 3'd1;
                end
                else
                begin
                    bytes_wanted_next = item.request_length;
                    bytes_done_next   = '0;
                    start_time_next   = item.now_ms;
                    phase_next        = rfh_pkg::PH_ACTIVE;
                end
            end
            rfh_pkg::MODE_POLL:
            begin
                bundle.count = 3'd1;
                if (phase_reg != rfh_pkg::PH_ACTIVE)
                begin
                    status_res.status_code = rfh_pkg::ST_INVALID;
                end
                else if (item.cancel_flag)
                begin
                    status_res.status_code = rfh_pkg::ST_CANCELLED;
                    phase_next             = rfh_pkg::PH_IDLE;
                end
                else if (failed_latch_reg)
                begin
                    status_res.status_code = rfh_pkg::ST_HEALTH;
                    phase_next             = rfh_pkg::PH_IDLE;
                end
                else if (timed_out)
                begin
                    status_res.status_code = rfh_pkg::ST_TIMEOUT;
                    phase_next             = rfh_pkg::PH_IDLE;
                end
                else if (absent)
                begin
                    status_res.status_code = rfh_pkg::ST_NOT_READY;
                    phase_next             = rfh_pkg::PH_IDLE;
                end
                else if (health_bits)
                begin
                    failed_latch_next      = 1'b1;
                    status_res.status_code = rfh_pkg::ST_HEALTH;
                    phase_next             = rfh_pkg::PH_IDLE;
                end
                else if (!enabled || item.fifo_count == '1)
                begin
                    status_res.status_code = rfh_pkg::ST_NOT_READY;
                    phase_next             = rfh_pkg::PH_IDLE;
                end
                else if (waiting)
                begin
                    status_res.status_code = rfh_pkg::ST_WAITING;
                end
                else
                begin
                    repeat_count_next  = rep_calc;
                    previous_word_next = item.fifo_word;
                    if (rep_calc >= 3'(rfh_pkg::REPEAT_FAIL))
                    begin
                        failed_latch_next      = 1'b1;
                        status_res.status_code = rfh_pkg::ST_HEALTH;
                        phase_next             = rfh_pkg::PH_IDLE;
                    end
                    else
                    begin
                        bytes_done_next = bytes_done_reg + rfh_pkg::LEN_W'(n);
                        if (bytes_done_next >= bytes_wanted_reg)
                        begin
                            phase_next = rfh_pkg::PH_CLOSING;
                        end
                        if (n == 3'd0)
                        begin
                            status_res.status_code = rfh_pkg::ST_WAITING;
                        end
                        else
                        begin
                            bundle.count = n;
                        end
                    end
                end
            end
            rfh_pkg::MODE_CLOSE:
            begin
                bundle.count = 3'd1;
                phase_next   = rfh_pkg::PH_IDLE;
                if (phase_reg != rfh_pkg::PH_CLOSING)
                begin
                    status_res.status_code = rfh_pkg::ST_INVALID;
                end
                else if (item.status_word == '1)
                begin
                    status_res.status_code = rfh_pkg::ST_NOT_READY;
                end
                else if (health_bits)
                begin
                    failed_latch_next      = 1'b1;
                    status_res.status_code = rfh_pkg::ST_HEALTH;
                end
                else
                begin
                    status_res.status_code = rfh_pkg::ST_OK;
                end
            end
            default:
            begin
                bundle.count = 3'd0;
            end
        endcase

        // data beats are only used when the poll delivered bytes
        for (int i = 0; i < 4; i++)
        begin
            bundle.res[i].kind        = rfh_pkg::KIND_DATA;
            bundle.res[i].byte_value  = item.fifo_word[i*8 +: 8];
            bundle.res[i].status_code = rfh_pkg::ST_OK;
            bundle.res[i].last        = (3'(i + 1) == n);
        end
        if (status_res.status_code != rfh_pkg::ST_OK || item.mode != rfh_pkg::MODE_POLL
            || bundle.count == 3'd1 && n == 3'd0)
        begin
            bundle.res[0] = status_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_latch_reg  <= 1'b0;
            repeat_count_reg  <= 3'd0;
            previous_word_reg <= '0;
            bytes_done_reg    <= '0;
            bytes_wanted_reg  <= '0;
            start_time_reg    <= '0;
            phase_reg         <= rfh_pkg::PH_IDLE;
        end
        else if (fire)
        begin
            failed_latch_reg  <= failed_latch_next;
            repeat_count_reg  <= repeat_count_next;
            previous_word_reg <= previous_word_next;
            bytes_done_reg    <= bytes_done_next;
            bytes_wanted_reg  <= bytes_wanted_next;
            start_time_reg    <= start_time_next;
            phase_reg         <= phase_next;
        end
    end

    a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        failed_latch_reg |=> failed_latch_reg)
        else $error("failure latch cleared");

    a_active_owes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rfh_pkg::PH_ACTIVE |-> bytes_done_reg < bytes_wanted_reg)
        else $error("active request owes no bytes");

    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("phase register holds unused code");

endmodule

// ===== src/rfh_outbuf.sv =====
// Result buffer: takes up to four results at once and hands them out one beat a cycle while out_stall is low.
module rfh_outbuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  rfh_pkg::res_bundle_t bundle,
    output logic                 can_load,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rfh_pkg::result_t     head
);

    rfh_pkg::result_t [3:0] res_reg;
    logic [2:0]             cnt_reg;
    logic                   pop;

    assign out_valid = cnt_reg != 3'd0;
    assign pop       = out_valid && !out_stall;
    assign can_load  = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && !out_stall);
    assign head      = res_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else if (load)
        begin
            cnt_reg <= bundle.count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= bundle.res;
        end
        else if (pop)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
            res_reg[2] <= res_reg[3];
        end
    end

    a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> cnt_reg == 3'd0 || (cnt_reg == 3'd1 && pop))
        else $error("results overwritten before delivery");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result count out of range");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cnt_reg == 3'd1 |-> head.last)
        else $error("final beat of an item lacks last");

endmodule

// ===== src/rng_fifo_health_reader.sv =====
// Top level of the RNG FIFO health reader: input register, configuration and result delivery.
// An accepted item waits in the input register until the result buffer can load and is evaluated
// there in a single pass; its results (none, one status, or up to four data bytes little-endian)
// are loaded into the result buffer, which delivers one beat per cycle while out_stall is low.
// A new item is taken into the input register while earlier results still drain, but it
// waits there until the buffer is down to its final beat. A valid start has no beat and
// leaves a gap on the output when it follows other results. The first result comes out
// of the result buffer after the item has passed the input register.
// Configuration is always ready and takes effect on the next item.
module rng_fifo_health_reader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [12:0] request_length,
    input  logic [31:0] now_ms,
    input  logic        cancel_flag,
    input  logic [31:0] control_word,
    input  logic [31:0] status_word,
    input  logic [31:0] bit_count,
    input  logic [31:0] fifo_count,
    input  logic [31:0] fifo_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  byte_value,
    output logic [2:0]  status_code,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    rfh_pkg::item_t       item_reg;
    logic                 in_valid_reg;
    rfh_pkg::cfg_t        cfg_reg;
    rfh_pkg::res_bundle_t bundle;
    rfh_pkg::result_t     head;
    logic                 can_load;
    logic                 fire;
    logic                 accept;

    assign fire      = in_valid_reg && can_load;
    assign in_stall  = in_valid_reg && !can_load;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.mode           <= mode;
            item_reg.request_length <= request_length;
            item_reg.now_ms         <= now_ms;
            item_reg.cancel_flag    <= cancel_flag;
            item_reg.control_word   <= control_word;
            item_reg.status_word    <= status_word;
            item_reg.bit_count      <= bit_count;
            item_reg.fifo_count     <= fifo_count;
            item_reg.fifo_word      <= fifo_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.failure_mask <= 32'd0;
            cfg_reg.enable_mask  <= 32'd1;
            cfg_reg.timeout_ms   <= 16'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rfh_pkg::REG_FAILURE_MASK: cfg_reg.failure_mask <= cfg_data;
                rfh_pkg::REG_ENABLE_MASK:  cfg_reg.enable_mask  <= cfg_data;
                rfh_pkg::REG_TIMEOUT_MS:   cfg_reg.timeout_ms   <= cfg_data[15:0];
                default:                   ;
            endcase
        end
    end

    rfh_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .bundle (bundle)
    );

    rfh_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .bundle    (bundle),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind        = head.kind;
    assign byte_value  = head.byte_value;
    assign status_code = head.status_code;
    assign last        = head.last;

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the RNG FIFO health reader: queued item driver, beat monitor, predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int GAP_PCT = 24;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    rfh_pkg::item_t cur_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic kind;
    logic [7:0] byte_value;
    logic [2:0] status_code;
    logic last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // predictor copy of the registers and the request state
    logic [31:0] cf_fail_mask = 32'd0;
    logic [31:0] cf_en_mask = 32'd1;
    logic [15:0] cf_tmo = 16'd1000;
    logic lat_fail = 1'b0;
    logic [2:0] rep_cnt = 3'd0;
    logic [31:0] prev_word = 32'd0;
    logic [12:0] done_bytes = '0;
    logic [12:0] want_bytes = '0;
    logic [31:0] req_t0 = 32'd0;
    logic [1:0] req_phase = rfh_pkg::PH_IDLE;

    rfh_pkg::item_t queued_items[$];
    rfh_pkg::result_t owed_beats[$];

    // stimulus bookkeeping
    logic [31:0] g_t0 = 32'd0;
    logic [31:0] g_word = 32'd0;
    int g_run = 0;
    int rep_lim = 3;
    logic [31:0] guard_mask = 32'd0;
    int n_offered = 0;

    logic no_gaps = 1'b0;
    logic hold_ask = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;

    int n_taken = 0;
    int n_beats = 0;
    int bad_beats = 0;

    rng_fifo_health_reader dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(cur_item.mode),
        .request_length(cur_item.request_length),
        .now_ms(cur_item.now_ms),
        .cancel_flag(cur_item.cancel_flag),
        .control_word(cur_item.control_word),
        .status_word(cur_item.status_word),
        .bit_count(cur_item.bit_count),
        .fifo_count(cur_item.fifo_count),
        .fifo_word(cur_item.fifo_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .byte_value(byte_value),
        .status_code(status_code),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void say_status(logic [2:0] code);
        rfh_pkg::result_t r;
        r.kind = rfh_pkg::KIND_STATUS;
        r.byte_value = 8'd0;
        r.status_code = code;
        r.last = 1'b1;
        owed_beats.push_back(r);
    endfunction

    function automatic void finish_with(logic [2:0] code);
        req_phase = rfh_pkg::PH_IDLE;
        say_status(code);
    endfunction

    // works out the beats one accepted item causes and advances the request state
    function automatic void read_fifo_item(rfh_pkg::item_t it);
        logic [31:0] age;
        int owing;
        int n;
        rfh_pkg::result_t r;
        age = it.now_ms - req_t0;
        case (it.mode)
            rfh_pkg::MODE_START:
            begin
                if (it.request_length == 0 || it.request_length > rfh_pkg::MAX_BYTES)
                begin
                    finish_with(rfh_pkg::ST_INVALID);
                end
                else
                begin
                    want_bytes = it.request_length;
                    done_bytes = '0;
                    req_t0 = it.now_ms;
                    req_phase = rfh_pkg::PH_ACTIVE;
                end
            end
            rfh_pkg::MODE_POLL:
            begin
                if (req_phase != rfh_pkg::PH_ACTIVE)
                    say_status(rfh_pkg::ST_INVALID);
                else if (it.cancel_flag)
                    finish_with(rfh_pkg::ST_CANCELLED);
                else if (lat_fail)
                    finish_with(rfh_pkg::ST_HEALTH);
                else if (age >= {16'd0, cf_tmo})
                    finish_with(rfh_pkg::ST_TIMEOUT);
                else if (it.control_word == '1 || it.status_word == '1)
                    finish_with(rfh_pkg::ST_NOT_READY);
                else if ((it.status_word & cf_fail_mask) != 0)
                begin
                    lat_fail = 1'b1;
                    finish_with(rfh_pkg::ST_HEALTH);
                end
                else if ((it.control_word & cf_en_mask) == 0)
                    finish_with(rfh_pkg::ST_NOT_READY);
                else if (it.fifo_count == '1)
                    finish_with(rfh_pkg::ST_NOT_READY);
                else if (it.bit_count <= rfh_pkg::WAIT_BITS || it.fifo_count[7:0] == 8'd0)
                    say_status(rfh_pkg::ST_WAITING);
                else
                begin
                    if (rep_cnt != 0 && prev_word == it.fifo_word)
                        rep_cnt = (rep_cnt < 3'd7) ? rep_cnt + 3'd1 : 3'd7;
                    else
                        rep_cnt = 3'd1;
                    prev_word = it.fifo_word;
                    if (rep_cnt >= rfh_pkg::REPEAT_FAIL)
                    begin
                        lat_fail = 1'b1;
                        finish_with(rfh_pkg::ST_HEALTH);
                    end
                    else
                    begin
                        owing = (want_bytes > done_bytes) ? int'(want_bytes - done_bytes) : 0;
                        n = (owing < 4) ? owing : 4;
                        for (int i = 0; i < n; i++)
                        begin
                            r.kind = rfh_pkg::KIND_DATA;
                            r.byte_value = it.fifo_word[i*8 +: 8];
                            r.status_code = rfh_pkg::ST_OK;
                            r.last = (i == n - 1);
                            owed_beats.push_back(r);
                        end
                        done_bytes = done_bytes + 13'(n);
                        if (done_bytes >= want_bytes)
                            req_phase = rfh_pkg::PH_CLOSING;
                        if (n == 0)
                            say_status(rfh_pkg::ST_WAITING);
                    end
                end
            end
            rfh_pkg::MODE_CLOSE:
            begin
                if (req_phase != rfh_pkg::PH_CLOSING)
                    finish_with(rfh_pkg::ST_INVALID);
                else if (it.status_word == '1)
                    finish_with(rfh_pkg::ST_NOT_READY);
                else if ((it.status_word & cf_fail_mask) != 0)
                begin
                    lat_fail = 1'b1;
                    finish_with(rfh_pkg::ST_HEALTH);
                end
                else
                    finish_with(rfh_pkg::ST_OK);
            end
            default: ;
        endcase
    endfunction

    // item driver: a new beat only once the current one has gone
    always @(posedge clk or negedge rst_n)
    begin : feed
        rfh_pkg::item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                read_fifo_item(cur_item);
                n_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (queued_items.size() != 0 && (no_gaps || $urandom_range(0, 99) >= GAP_PCT))
                begin
                    nxt = queued_items.pop_front();
                    cur_item <= nxt;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output back-pressure, with one long hold so the block backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_ask && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_stall <= !no_gaps && $urandom_range(0, 99) < GAP_PCT;
        end
    end

    always @(posedge clk)
    begin : watch
        rfh_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_beats++;
            if (owed_beats.size() == 0)
            begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("unexpected beat: kind %0d byte %02h status %0d last %0d",
                             kind, byte_value, status_code, last);
            end
            else
            begin
                want = owed_beats.pop_front();
                if (kind !== want.kind || byte_value !== want.byte_value ||
                    status_code !== want.status_code || last !== want.last)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display({"beat %0d: want kind %0d byte %02h status %0d last %0d,",
                                  " got kind %0d byte %02h status %0d last %0d"},
                                 n_beats, want.kind, want.byte_value, want.status_code,
                                 want.last, kind, byte_value, status_code, last);
                end
            end
        end
    end

    function automatic void offer(rfh_pkg::item_t it);
        queued_items.push_back(it);
        n_offered++;
    endfunction

    function automatic rfh_pkg::item_t noise();
        rfh_pkg::item_t it;
        it.mode = 2'($urandom_range(0, 3));
        it.request_length = 13'($urandom());
        it.now_ms = $urandom();
        it.cancel_flag = 1'($urandom());
        it.control_word = $urandom();
        it.status_word = $urandom() & ~guard_mask;
        it.bit_count = $urandom();
        it.fifo_count = $urandom();
        it.fifo_word = $urandom();
        return it;
    endfunction

    // a poll that should hand out data under the current settings
    function automatic rfh_pkg::item_t good_poll();
        rfh_pkg::item_t it;
        logic [31:0] w;
        it = noise();
        it.mode = rfh_pkg::MODE_POLL;
        it.now_ms = g_t0 + ((cf_tmo == 0) ? 32'd0 : $urandom_range(0, int'(cf_tmo) - 1));
        it.cancel_flag = 1'b0;
        w = cf_en_mask & (~cf_en_mask + 32'd1);
        it.control_word = it.control_word | w;
        w = $urandom();
        it.fifo_count = {w[31:8], (w[7:0] == 8'd0) ? 8'd1 : w[7:0]};
        return it;
    endfunction

    function automatic void open_request(int len, logic [31:0] t);
        rfh_pkg::item_t it;
        it = noise();
        it.mode = rfh_pkg::MODE_START;
        it.request_length = 13'(len);
        it.now_ms = t;
        g_t0 = t;
        offer(it);
    endfunction

    // short runs of a repeated word, kept under the failure count where it matters
    function automatic logic [31:0] pick_word();
        if (g_run != 0 && g_run < rep_lim && $urandom_range(0, 5) == 0)
        begin
            g_run++;
        end
        else
        begin
            g_word = $urandom();
            g_run = 1;
        end
        return g_word;
    endfunction

    function automatic void run_request();
        rfh_pkg::item_t it;
        int len;
        int left;
        int polls;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(1, 16);
        else if (r < 90)
            len = $urandom_range(17, 64);
        else if (r < 95)
            len = r[0] ? rfh_pkg::MAX_BYTES
                       : $urandom_range(rfh_pkg::MAX_BYTES - 64, rfh_pkg::MAX_BYTES);
        else
            len = ($urandom_range(0, 1) != 0) ? 0
                                              : $urandom_range(rfh_pkg::MAX_BYTES + 1, 8191);
        open_request(len, $urandom());
        if (len == 0 || len > rfh_pkg::MAX_BYTES)
            return;
        left = len;
        polls = 0;
        while (left > 0)
        begin
            polls++;
            it = good_poll();
            r = (polls > 20) ? 0 : $urandom_range(0, 99);
            if (r < 4)
            begin
                case ($urandom_range(0, 5))
                    0: it.cancel_flag = 1'b1;
                    1: it.now_ms = g_t0 + cf_tmo + $urandom_range(0, 5000);
                    2: it.control_word = '1;
                    3: it.status_word = '1;
                    4: it.control_word = it.control_word & ~cf_en_mask;
                    default: it.fifo_count = '1;
                endcase
                offer(it);
                return;
            end
            if (r < 6)
                return;     // left hanging, the next start replaces it
            if (r < 16)
            begin
                if (r[0])
                    it.bit_count = $urandom_range(0, rfh_pkg::WAIT_BITS);
                else
                    it.fifo_count[7:0] = 8'd0;
                offer(it);
                continue;
            end
            it.fifo_word = pick_word();
            offer(it);
            left -= (left < 4) ? left : 4;
        end
        it = good_poll();
        it.mode = rfh_pkg::MODE_CLOSE;
        r = $urandom_range(0, 99);
        if (r < 6)
            it.status_word = '1;
        offer(it);
        if (r >= 94)
        begin
            it = good_poll();
            it.mode = rfh_pkg::MODE_CLOSE;
            offer(it);
        end
    endfunction

    function automatic void fill_until(int goal, int noise_pct);
        while (n_offered < goal)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                offer(noise());
            else
                run_request();
        end
    endfunction

    task automatic set_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rfh_pkg::REG_FAILURE_MASK: cf_fail_mask = val;
            rfh_pkg::REG_ENABLE_MASK: cf_en_mask = val;
            default: cf_tmo = val[15:0];
        endcase
    endtask

    task automatic configure(logic [31:0] fmask, logic [31:0] emask, logic [15:0] tmo);
        set_reg(rfh_pkg::REG_FAILURE_MASK, fmask);
        set_reg(rfh_pkg::REG_ENABLE_MASK, emask);
        set_reg(rfh_pkg::REG_TIMEOUT_MS, {16'd0, tmo});
        cfg_valid <= 1'b0;
        guard_mask = cf_fail_mask;
    endtask

    // everything sent and answered, then a margin for items that answer nothing
    task automatic drain();
        while (queued_items.size() != 0 || in_valid || owed_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin : stim
        rfh_pkg::item_t it;
        logic [31:0] w;
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        @(posedge clk);

        configure(32'd0, 32'd1, 16'd1000);
        it = noise();
        it.mode = rfh_pkg::MODE_POLL;
        offer(it);
        open_request(0, $urandom());
        open_request(rfh_pkg::MAX_BYTES + 1, $urandom());
        it = noise();
        it.mode = MODE_SPARE;
        offer(it);
        // one-byte request across the clock wrap
        open_request(1, 32'hFFFF_FF00);
        it = good_poll();
        it.bit_count = rfh_pkg::WAIT_BITS;
        offer(it);
        it = good_poll();
        it.fifo_count = 32'hFFFF_FF00;
        offer(it);
        it = good_poll();
        it.now_ms = 32'h0000_00E7;
        it.bit_count = rfh_pkg::WAIT_BITS + 1;
        offer(it);
        it = good_poll();
        it.mode = rfh_pkg::MODE_CLOSE;
        it.status_word = '0;
        offer(it);
        // three equal words in a row still pass
        open_request(rfh_pkg::MAX_BYTES, $urandom());
        w = $urandom();
        repeat (3)
        begin
            it = good_poll();
            it.fifo_word = w;
            offer(it);
        end
        it = good_poll();
        it.control_word = '1;
        offer(it);
        open_request(8, $urandom());
        it = good_poll();
        it.status_word = '1;
        offer(it);
        open_request(8, $urandom());
        it = good_poll();
        it.control_word = 32'hFFFF_FFFE;
        offer(it);
        open_request(8, $urandom());
        it = good_poll();
        it.fifo_count = '1;
        offer(it);
        open_request(8, $urandom());
        it = good_poll();
        it.cancel_flag = 1'b1;
        offer(it);
        open_request(8, $urandom());
        it = good_poll();
        it.now_ms = g_t0 + cf_tmo;
        offer(it);
        open_request(5, $urandom());
        open_request(6, $urandom());
        offer(good_poll());
        it = good_poll();
        it.mode = rfh_pkg::MODE_CLOSE;
        offer(it);
        open_request(2, $urandom());
        it = good_poll();
        it.now_ms = g_t0 + cf_tmo - 1;
        offer(it);
        it = good_poll();
        it.mode = rfh_pkg::MODE_CLOSE;
        it.status_word = '1;
        offer(it);
        g_run = 0;
        drain();

        configure($urandom(), '1, 16'hFFFF);
        fill_until(230, 15);
        drain();

        // no gaps on either side, apart from one long output hold
        configure(32'h8000_0000, 32'd1 << $urandom_range(0, 31), 16'd1);
        no_gaps <= 1'b1;
        hold_ask <= 1'b1;
        fill_until(380, 10);
        drain();
        no_gaps <= 1'b0;

        configure($urandom(), 32'd0, 16'd0);
        fill_until(n_offered + 12, 20);
        drain();

        configure($urandom(), 32'd0, 16'($urandom_range(2, 65535)));
        fill_until(n_offered + 12, 20);
        drain();

        // health failure latches for the rest of the run
        configure('1, $urandom() | 32'd1, 16'($urandom_range(2, 65535)));
        case ($urandom_range(0, 2))
            0:
            begin
                open_request(32, $urandom());
                w = $urandom();
                repeat (rfh_pkg::REPEAT_FAIL)
                begin
                    it = good_poll();
                    it.fifo_word = w;
                    offer(it);
                end
            end
            1:
            begin
                open_request(8, $urandom());
                it = good_poll();
                it.status_word = 32'd1;
                offer(it);
            end
            default:
            begin
                open_request(4, $urandom());
                offer(good_poll());
                it = good_poll();
                it.mode = rfh_pkg::MODE_CLOSE;
                it.status_word = 32'h8000_0000;
                offer(it);
            end
        endcase
        guard_mask = 32'd0;
        rep_lim = 7;
        fill_until(n_offered + 60, 25);
        drain();

        $display("covered %0d items in, %0d result beats checked, %0d bad",
                 n_taken, n_beats, bad_beats + owed_beats.size());
        $display("six register sets, timeouts 0 to 65535, a long output hold, latched health failure");
        if (bad_beats == 0 && owed_beats.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("watchdog expired, %0d beats still owed", owed_beats.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rfh_pkg.sv
src/rfh_core.sv
src/rfh_outbuf.sv
src/rng_fifo_health_reader.sv
verif/testbench.sv
